// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bpsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpsd_pkg;

   localparam int unsigned MaxDim        = 4096;
   localparam int unsigned HdrLen        = 14 + 40;
   localparam int unsigned OffWidth      = 14 + 4;
   localparam int unsigned OffHeight     = 14 + 8;
   localparam int unsigned OffDepth      = 14 + 14;
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [7:0] SigFirst    = 8'h42;
   localparam logic [7:0] SigSecond   = 8'h4D;
   localparam logic [7:0] Depth24     = 8'd24;
   localparam logic [7:0] Depth32     = 8'd32;
   localparam logic [7:0] AlphaOpaque = 8'hFF;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SHORT     = 3'd1,
      ERR_SIGNATURE = 3'd2,
      ERR_DEPTH     = 3'd3,
      ERR_TOO_LARGE = 3'd4,
      ERR_TRUNCATED = 3'd5
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic        done;
      logic [11:0] column;
      logic [11:0] row;
      logic [12:0] width;
      logic [12:0] height;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      err_type     err;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/bpsd_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bpsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;
   logic       end_of_file;

   modport source (output valid, output data_byte, output start_of_file,
                   output end_of_file, input ready);
   modport sink (input valid, input data_byte, input start_of_file,
                 input end_of_file, output ready);
endinterface

interface bpsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        image_done;
   logic [25:0] byte_offset;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic [12:0] image_width;
   logic [12:0] image_height;
   logic [2:0]  error_code;

   modport source (output valid, output kind, output image_done, output byte_offset,
                   output red, output green, output blue, output alpha,
                   output image_width, output image_height, output error_code,
                   input ready);
   modport sink (input valid, input kind, input image_done, input byte_offset,
                 input red, input green, input blue, input alpha,
                 input image_width, input image_height, input error_code,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/bpsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpsd_front (
   input  wire logic       clock,
   input  wire logic       reset,
   bpsd_req_if.sink        req_if,
   input  wire logic       queue_full,
   output logic            push,
   output bpsd_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_IDLE
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [5:0]  count_ff, count_in, cur_count;
   logic        sig_ff, sig_in, cur_sig;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic        four_ff, four_in;
   logic [15:0] bg_ff, bg_in;
   logic [7:0]  red_ff, red_in;
   logic [1:0]  bip_ff, bip_in;
   logic [11:0] column_ff, column_in;
   logic [11:0] row_ff, row_in;
   logic [1:0]  pad_ff, pad_in;

   logic        accept;
   logic [7:0]  byte_val;
   logic [1:0]  lane_w, lane_h, last_bip, pad_val;
   logic        w_pos, h_pos, too_large;
   logic [12:0] next_col;
   logic        eof_header;

   assign req_if.ready = !queue_full;

   always_comb begin
      accept    = req_if.valid && req_if.ready;
      byte_val  = req_if.data_byte;
      cur_phase = req_if.start_of_file ? PH_HEADER : phase_ff;
      cur_count = req_if.start_of_file ? 6'd0 : count_ff;
      cur_sig   = req_if.start_of_file ? 1'b0 : sig_ff;
      lane_w    = 2'(cur_count - 6'(bpsd_pkg::OffWidth));
      lane_h    = 2'(cur_count - 6'(bpsd_pkg::OffHeight));
      last_bip  = four_ff ? 2'd3 : 2'd2;
      pad_val   = four_ff ? 2'd0 : width_ff[1:0];
      next_col  = {1'b0, column_ff} + 13'd1;
      w_pos     = (width_ff != 32'd0) && !width_ff[31];
      h_pos     = (height_ff != 32'd0) && !height_ff[31];
      too_large = (width_ff > 32'(bpsd_pkg::MaxDim)) || (height_ff > 32'(bpsd_pkg::MaxDim));
      eof_header = 1'b0;

      phase_in  = phase_ff;
      count_in  = count_ff;
      sig_in    = sig_ff;
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      four_in   = four_ff;
      bg_in     = bg_ff;
      red_in    = red_ff;
      bip_in    = bip_ff;
      column_in = column_ff;
      row_in    = row_ff;
      pad_in    = pad_ff;
      push      = 1'b0;
      cmd       = '0;

      if (accept) begin
         phase_in = cur_phase;
         count_in = cur_count;
         sig_in   = cur_sig;
         case (cur_phase)
            PH_HEADER: begin
               if (cur_count == 6'd0 && byte_val != bpsd_pkg::SigFirst) sig_in = 1'b1;
               if (cur_count == 6'd1 && byte_val != bpsd_pkg::SigSecond) sig_in = 1'b1;
               if (cur_count >= 6'(bpsd_pkg::OffWidth) &&
                   cur_count < 6'(bpsd_pkg::OffWidth + 4)) begin
                  width_in[{lane_w, 3'b000} +: 8] = byte_val;
               end
               if (cur_count >= 6'(bpsd_pkg::OffHeight) &&
                   cur_count < 6'(bpsd_pkg::OffHeight + 4)) begin
                  height_in[{lane_h, 3'b000} +: 8] = byte_val;
               end
               if (cur_count == 6'(bpsd_pkg::OffDepth)) depth_in = byte_val;
               if (cur_count == 6'(bpsd_pkg::HdrLen - 1)) begin
                  phase_in = PH_IDLE;
                  push     = 1'b1;
                  if (cur_sig) begin
                     cmd.kind = bpsd_pkg::KIND_ERROR;
                     cmd.err  = bpsd_pkg::ERR_SIGNATURE;
                  end else if (depth_ff != bpsd_pkg::Depth24 &&
                               depth_ff != bpsd_pkg::Depth32) begin
                     cmd.kind = bpsd_pkg::KIND_ERROR;
                     cmd.err  = bpsd_pkg::ERR_DEPTH;
                  end else if (!w_pos || !h_pos) begin
                     cmd.kind = bpsd_pkg::KIND_HEADER;
                     cmd.done = 1'b1;
                  end else if (too_large) begin
                     cmd.kind = bpsd_pkg::KIND_ERROR;
                     cmd.err  = bpsd_pkg::ERR_TOO_LARGE;
                  end else begin
                     four_in    = (depth_ff == bpsd_pkg::Depth32);
                     row_in     = 12'(height_ff - 32'd1);
                     column_in  = 12'd0;
                     bip_in     = 2'd0;
                     pad_in     = 2'd0;
                     phase_in   = PH_PIXELS;
                     cmd.kind   = bpsd_pkg::KIND_HEADER;
                     cmd.width  = width_ff[12:0];
                     cmd.height = height_ff[12:0];
                  end
               end else begin
                  count_in = cur_count + 6'd1;
               end
            end
            PH_PIXELS: begin
               if (pad_ff != 2'd0) begin
                  pad_in = pad_ff - 2'd1;
                  if (pad_ff == 2'd1) begin
                     if (row_ff == 12'd0) begin
                        phase_in   = PH_IDLE;
                        push       = 1'b1;
                        cmd.kind   = bpsd_pkg::KIND_HEADER;
                        cmd.done   = 1'b1;
                        cmd.width  = width_ff[12:0];
                        cmd.height = height_ff[12:0];
                     end else begin
                        row_in = row_ff - 12'd1;
                     end
                  end
               end else begin
                  case (bip_ff)
                     2'd0:    bg_in[7:0]  = byte_val;
                     2'd1:    bg_in[15:8] = byte_val;
                     2'd2:    red_in      = byte_val;
                     default: ;
                  endcase
                  if (bip_ff >= last_bip) begin
                     push       = 1'b1;
                     cmd.kind   = bpsd_pkg::KIND_PIXEL;
                     cmd.column = column_ff;
                     cmd.row    = row_ff;
                     cmd.width  = width_ff[12:0];
                     cmd.height = height_ff[12:0];
                     cmd.red    = (bip_ff == 2'd2) ? byte_val : red_ff;
                     cmd.green  = bg_ff[15:8];
                     cmd.blue   = bg_ff[7:0];
                     bip_in     = 2'd0;
                     if (next_col >= width_ff[12:0]) begin
                        column_in = 12'd0;
                        if (pad_val != 2'd0) begin
                           pad_in = pad_val;
                        end else if (row_ff == 12'd0) begin
                           phase_in = PH_IDLE;
                           cmd.done = 1'b1;
                        end else begin
                           row_in = row_ff - 12'd1;
                        end
                     end else begin
                        column_in = next_col[11:0];
                     end
                  end else begin
                     bip_in = bip_ff + 2'd1;
                  end
               end
            end
            default: ;
         endcase
         if (req_if.end_of_file && (phase_in == PH_HEADER || phase_in == PH_PIXELS)) begin
            eof_header = (phase_in == PH_HEADER);
            phase_in   = PH_IDLE;
            push       = 1'b1;
            cmd        = '0;
            cmd.kind   = bpsd_pkg::KIND_ERROR;
            cmd.err    = eof_header ? bpsd_pkg::ERR_SHORT : bpsd_pkg::ERR_TRUNCATED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= 6'd0;
         sig_ff    <= 1'b0;
         width_ff  <= 32'd0;
         height_ff <= 32'd0;
         depth_ff  <= 8'd0;
         four_ff   <= 1'b0;
         bip_ff    <= 2'd0;
         column_ff <= 12'd0;
         row_ff    <= 12'd0;
         pad_ff    <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         sig_ff    <= sig_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         four_ff   <= four_in;
         bip_ff    <= bip_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
      end
      bg_ff  <= bg_in;
      red_ff <= red_in;
   end

endmodule

`default_nettype wire

// ===== rtl/bpsd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpsd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bpsd_pkg::cmd_type push_data,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output bpsd_pkg::cmd_type      head
);

   bpsd_pkg::cmd_type mem_ff [bpsd_pkg::QueueDepth];

   logic [bpsd_pkg::QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bpsd_pkg::QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bpsd_pkg::QueuePtrWidth:0]   count_ff, count_in;
   logic                               do_push, do_pop;

   always_comb begin
      full      = (count_ff == (bpsd_pkg::QueuePtrWidth + 1)'(bpsd_pkg::QueueDepth));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ===== rtl/bpsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpsd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  wire bpsd_pkg::cmd_type head,
   output logic                   pop,
   bpsd_rsp_if.source             rsp_if
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic        done_ff;
   logic [25:0] offset_ff, offset_in;
   logic [7:0]  red_ff, green_ff, blue_ff, alpha_ff;
   logic [12:0] width_ff, height_ff;
   logic [2:0]  err_ff;

   logic        is_pixel;
   logic [24:0] prod;
   logic [25:0] sum;

   always_comb begin
      pop       = !queue_empty && (!valid_ff || rsp_if.ready);
      is_pixel  = (head.kind == bpsd_pkg::KIND_PIXEL);
      prod      = 25'(head.row) * 25'(head.width);
      sum       = 26'(prod) + 26'(head.column);
      offset_in = is_pixel ? {sum[23:0], 2'b00} : 26'd0;
      valid_in  = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         kind_ff   <= head.kind;
         done_ff   <= head.done;
         offset_ff <= offset_in;
         red_ff    <= head.red;
         green_ff  <= head.green;
         blue_ff   <= head.blue;
         alpha_ff  <= is_pixel ? bpsd_pkg::AlphaOpaque : 8'd0;
         width_ff  <= head.width;
         height_ff <= head.height;
         err_ff    <= head.err;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.kind         = kind_ff;
   assign rsp_if.image_done   = done_ff;
   assign rsp_if.byte_offset  = offset_ff;
   assign rsp_if.red          = red_ff;
   assign rsp_if.green        = green_ff;
   assign rsp_if.blue         = blue_ff;
   assign rsp_if.alpha        = alpha_ff;
   assign rsp_if.image_width  = width_ff;
   assign rsp_if.image_height = height_ff;
   assign rsp_if.error_code   = err_ff;

endmodule

`default_nettype wire

// ===== rtl/bmp_pixel_stream_decoder_unit.sv =====
// Channel  Direction  Payload                                               Accepted when
// req_if   in         data_byte, start_of_file, end_of_file                 valid && ready
// rsp_if   out        kind, image_done, byte_offset, red, green, blue,      valid && ready
//                     alpha, image_width, image_height, error_code
//
// One file byte per cycle while ready; a result is queued, then held in the output register.
// Parser state updates in one step per byte; the offset multiply sits in the back stage.
// Synchronous reset; the parser then waits for header byte 0.
// ready drops only while the two-entry queue is full behind a stalled rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module bmp_pixel_stream_decoder_unit (
   input wire logic    clock,
   input wire logic    reset,
   bpsd_req_if.sink    req_if,
   bpsd_rsp_if.source  rsp_if
);

   logic              push, pop, queue_full, queue_empty;
   bpsd_pkg::cmd_type cmd, head;

   bpsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (cmd)
   );

   bpsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   bpsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

`default_nettype wire

// ===== rtl/bpsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bpsd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic        rsp_image_done,
   input wire logic [25:0] rsp_byte_offset,
   input wire logic [7:0]  rsp_alpha,
   input wire logic [12:0] rsp_image_width,
   input wire logic [2:0]  rsp_error_code
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_byte_offset) && $stable(rsp_kind))
   `ASSERT_IMPLY(a_pixel_alpha, clock, reset, rsp_valid && rsp_kind == bpsd_pkg::KIND_PIXEL, rsp_alpha == bpsd_pkg::AlphaOpaque && rsp_error_code == bpsd_pkg::ERR_NONE)
   `ASSERT_IMPLY(a_error_clean, clock, reset, rsp_valid && rsp_kind == bpsd_pkg::KIND_ERROR, rsp_error_code != bpsd_pkg::ERR_NONE && rsp_image_width == 13'd0 && !rsp_image_done)
   `ASSERT_IMPLY(a_nonpixel_zero, clock, reset, rsp_valid && rsp_kind != bpsd_pkg::KIND_PIXEL, rsp_byte_offset == 26'd0 && rsp_alpha == 8'd0)

endmodule

bind bmp_pixel_stream_decoder_unit bpsd_checker u_bpsd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_kind        (rsp_if.kind),
   .rsp_image_done  (rsp_if.image_done),
   .rsp_byte_offset (rsp_if.byte_offset),
   .rsp_alpha       (rsp_if.alpha),
   .rsp_image_width (rsp_if.image_width),
   .rsp_error_code  (rsp_if.error_code)
);

`default_nettype wire
